@@ design/mmd_pkg.sv @@
package mmd_pkg;

  // Default sizes of the block.
  localparam int MaxChannels = 8;
  localparam int MaxPixels   = 4096;

  // Most results that one input word may cause.
  localparam int MaxResults  = 64;

  // Depth of the queue between the front and the back.
  localparam int QueueDepth  = 4;

  // Fixed field widths.
  localparam int SampleW  = 16;
  localparam int PixelW   = 12;
  localparam int ChannelW = 3;
  localparam int WordW    = 32;
  localparam int AccumW   = 48;
  localparam int FracW    = 16;

  // Running min and max start from the opposite ends of the Q1.15 range.
  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = 16'sh8000;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FPP      = 2'd0,
    CFG_PIXELS   = 2'd1,
    CFG_CHANNELS = 2'd2,
    CFG_SPAN     = 2'd3
  } mmd_cfg_index_t;

  // Column sequencer states of the back part.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_RUN,
    ST_EMIT,
    ST_REFRESH,
    ST_DECIDE
  } mmd_state_t;

  // View geometry handed from the register bank to the back part.
  typedef struct packed {
    logic [WordW-1:0] fpp;
    logic [WordW-1:0] span;
  } mmd_geom_t;

endpackage

@@ design/waveform_minmax_decimator_core.sv @@
// A word that closes a column passes the queue and the RUN state; its first result is
// registered in EMIT, or in DECIDE for a single-channel column that does not end the view.
// Throughput: one sample per cycle while no column closes and the queue has room; each closed
// column pauses the pops of a four-word queue while one result per channel is emitted.
// Reset (rst, synchronous) restores the default registers and starts the view at frame 0;
// any configuration write also restarts the view and keeps the other register values.
module waveform_minmax_decimator_core import mmd_pkg::*; #(
  parameter int MAX_CHANNELS = MaxChannels,
  parameter int MAX_PIXELS   = MaxPixels
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [PixelW-1:0]         pixel,
  output logic [ChannelW-1:0]       channel,
  output logic signed [SampleW-1:0] low_value,
  output logic signed [SampleW-1:0] high_value,
  output logic                      last,
  output logic                      view_done,
  input  logic                      cfg_write,
  input  logic [1:0]                cfg_index,
  input  logic [WordW-1:0]          cfg_data
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int NPX_W  = $clog2(MAX_PIXELS + 1);
  localparam int ITEM_W = SampleW + CH_W + 1;

  // Configuration registers.
  logic [WordW-1:0] frames_per_pixel;
  logic [12:0]      pixel_count;
  logic [3:0]       channel_count;
  logic [WordW-1:0] span_frames;

  logic [NPX_W-1:0]  eff_npx;
  logic [NCH_W-1:0]  eff_nch;
  mmd_geom_t         geom;

  logic              push;
  logic [ITEM_W-1:0] push_item;
  logic              queue_full;
  logic              q_pop;
  logic              q_empty;
  logic [ITEM_W-1:0] q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_pixel <= WordW'(65536);
      pixel_count      <= 13'd1024;
      channel_count    <= 4'd2;
      span_frames      <= WordW'(1024);
    end else if (cfg_write) begin
      case (mmd_cfg_index_t'(cfg_index))
        CFG_FPP:      frames_per_pixel <= cfg_data;
        CFG_PIXELS:   pixel_count      <= cfg_data[12:0];
        CFG_CHANNELS: channel_count    <= cfg_data[3:0];
        CFG_SPAN:     span_frames      <= cfg_data;
        default:      frames_per_pixel <= frames_per_pixel;
      endcase
    end
  end

  // Out-of-range counts are clamped into the supported range.
  always_comb begin
    if (pixel_count == '0) begin
      eff_npx = NPX_W'(1);
    end else if (32'(pixel_count) > MAX_PIXELS) begin
      eff_npx = NPX_W'(MAX_PIXELS);
    end else begin
      eff_npx = NPX_W'(pixel_count);
    end
    if (channel_count == '0) begin
      eff_nch = NCH_W'(1);
    end else if (32'(channel_count) > MAX_CHANNELS) begin
      eff_nch = NCH_W'(MAX_CHANNELS);
    end else begin
      eff_nch = NCH_W'(channel_count);
    end
  end

  assign geom = '{fpp: frames_per_pixel, span: span_frames};

  mmd_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_write),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .nch        (eff_nch),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  mmd_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .flush     (cfg_write),
    .push      (push),
    .push_data (push_item),
    .full      (queue_full),
    .pop       (q_pop),
    .pop_data  (q_item),
    .empty     (q_empty)
  );

  mmd_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_PIXELS   (MAX_PIXELS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .restart    (cfg_write),
    .geom       (geom),
    .npx        (eff_npx),
    .nch        (eff_nch),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .pixel      (pixel),
    .channel    (channel),
    .low_value  (low_value),
    .high_value (high_value),
    .last       (last),
    .view_done  (view_done)
  );

endmodule

@@ design/mmd_front.sv @@
module mmd_front import mmd_pkg::*; #(
  parameter int MAX_CHANNELS = MaxChannels
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SampleW-1:0]            sample,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]    nch,
  input  logic                                 queue_full,
  output logic                                 push,
  output logic [SampleW+((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] push_item
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W  = ((CH_W > NCH_W) ? CH_W : NCH_W) + 1;

  logic [CH_W-1:0] ch;
  logic            frame_end;

  // A word is taken whenever the queue has room.
  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;

  // The word that carries the last channel of a frame closes the frame.
  assign frame_end = (CMP_W'(ch) + CMP_W'(1)) >= CMP_W'(nch);

  assign push_item = {sample, ch, frame_end};

  // Channel counter walks the interleave order.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ch <= '0;
    end else if (push) begin
      if (frame_end) begin
        ch <= '0;
      end else begin
        ch <= ch + CH_W'(1);
      end
    end
  end

endmodule

@@ design/mmd_queue.sv @@
module mmd_queue import mmd_pkg::*; #(
  parameter int WIDTH = SampleW,
  parameter int DEPTH = QueueDepth
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             flush,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = count == CNT_W'(DEPTH);
  assign empty    = count == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/mmd_back.sv @@
module mmd_back import mmd_pkg::*; #(
  parameter int MAX_CHANNELS = MaxChannels,
  parameter int MAX_PIXELS   = MaxPixels
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 restart,
  input  mmd_geom_t                            geom,
  input  logic [$clog2(MAX_PIXELS+1)-1:0]      npx,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]    nch,
  input  logic                                 q_empty,
  input  logic [SampleW+((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1):0] q_item,
  output logic                                 q_pop,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [PixelW-1:0]                    pixel,
  output logic [ChannelW-1:0]                  channel,
  output logic signed [SampleW-1:0]            low_value,
  output logic signed [SampleW-1:0]            high_value,
  output logic                                 last,
  output logic                                 view_done
);

  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CMP_W  = ((CH_W > NCH_W) ? CH_W : NCH_W) + 1;
  localparam int COL_W  = $clog2(MAX_PIXELS);
  localparam int NPX_W  = $clog2(MAX_PIXELS + 1);
  localparam int FC_W   = ((COL_W > NPX_W) ? COL_W : NPX_W) + 1;
  localparam int RES_W  = $clog2(MaxResults + 1);

  mmd_state_t state;
  mmd_state_t state_next;

  // Unpacked queue word.
  logic signed [SampleW-1:0] it_sample;
  logic [CH_W-1:0]           it_ch;
  logic                      it_fe;

  // Per-channel lanes of the open column.
  logic signed [SampleW-1:0] lane_min [MAX_CHANNELS];
  logic signed [SampleW-1:0] lane_max [MAX_CHANNELS];

  // Column state.
  logic [AccumW-1:0] accum;
  logic [COL_W-1:0]  col_idx;
  logic [WordW-1:0]  frame_idx;
  logic [WordW-1:0]  col_start;
  logic [WordW-1:0]  col_endb;
  logic [WordW-1:0]  col_close_m1;
  logic [CH_W-1:0]   emit_ch;
  logic [RES_W-1:0]  res_count;

  // Last result of a column waits here until the next column is judged.
  logic [COL_W-1:0]          hold_pixel;
  logic [CH_W-1:0]           hold_ch;
  logic signed [SampleW-1:0] hold_low;
  logic signed [SampleW-1:0] hold_high;

  // Control strobes.
  logic do_update;
  logic start_emit;
  logic next_ch;
  logic emit_out;
  logic emit_last;
  logic hold_load;
  logic advance;
  logic restart_view;
  logic refresh;
  logic frame_step;
  logic release_hold;
  logic release_last;
  logic chan_zero;

  // Derived values.
  logic                      out_free;
  logic                      final_col;
  logic                      last_emit;
  logic                      f_close;
  logic                      room;
  logic [RES_W:0]            res_sum;
  logic [WordW-1:0]          frame_inc;
  logic [AccumW-1:0]         acc_src;
  logic [WordW-1:0]          bound_raw;
  logic [WordW-1:0]          endb_new;
  logic [WordW-1:0]          close_new;
  logic signed [SampleW-1:0] sel_min;
  logic signed [SampleW-1:0] sel_max;

  assign it_sample = q_item[SampleW+CH_W -: SampleW];
  assign it_ch     = q_item[CH_W:1];
  assign it_fe     = q_item[0];

  assign out_free  = !out_valid || out_ready;
  assign final_col = (FC_W'(col_idx) + FC_W'(1)) >= FC_W'(npx);
  assign last_emit = (CMP_W'(emit_ch) + CMP_W'(1)) >= CMP_W'(nch);

  // The open column ends with the current frame once its last frame is reached.
  assign f_close   = col_close_m1 <= frame_idx;
  assign frame_inc = (frame_idx == '1) ? frame_idx : frame_idx + WordW'(1);

  // Another column fits only if its results stay within the per-word budget.
  assign res_sum = (RES_W+1)'(res_count) + (RES_W+1)'(nch);
  assign room    = res_sum <= (RES_W+1)'(MaxResults);

  assign sel_min = lane_min[emit_ch];
  assign sel_max = lane_max[emit_ch];

  // End boundary of the open column, and its last frame after widening.
  always_comb begin
    acc_src   = (state == ST_INIT) ? AccumW'(geom.fpp) : accum;
    bound_raw = acc_src[AccumW-1:FracW];
    if (final_col || (bound_raw > geom.span)) begin
      endb_new = geom.span;
    end else begin
      endb_new = bound_raw;
    end
    if (endb_new > col_start) begin
      close_new = endb_new - WordW'(1);
    end else begin
      close_new = col_start;
    end
  end

  // Next state and strobes of the column sequencer.
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    do_update    = 1'b0;
    start_emit   = 1'b0;
    next_ch      = 1'b0;
    emit_out     = 1'b0;
    emit_last    = 1'b0;
    hold_load    = 1'b0;
    advance      = 1'b0;
    restart_view = 1'b0;
    refresh      = 1'b0;
    frame_step   = 1'b0;
    release_hold = 1'b0;
    release_last = 1'b0;
    chan_zero    = 1'b0;
    case (state)
      ST_INIT: begin
        refresh    = 1'b1;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          do_update = 1'b1;
          if (it_fe) begin
            if (f_close) begin
              start_emit = 1'b1;
              state_next = ST_EMIT;
            end else begin
              frame_step = 1'b1;
            end
          end
        end
      end
      ST_EMIT: begin
        if (last_emit && !final_col) begin
          hold_load  = 1'b1;
          advance    = 1'b1;
          state_next = ST_REFRESH;
        end else if (out_free) begin
          emit_out = 1'b1;
          if (last_emit) begin
            emit_last    = 1'b1;
            restart_view = 1'b1;
            state_next   = ST_INIT;
          end else begin
            next_ch = 1'b1;
          end
        end
      end
      ST_REFRESH: begin
        refresh    = 1'b1;
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_free) begin
          release_hold = 1'b1;
          if (f_close && room) begin
            chan_zero  = 1'b1;
            state_next = ST_EMIT;
          end else begin
            release_last = 1'b1;
            frame_step   = 1'b1;
            state_next   = ST_RUN;
          end
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
    if (restart) begin
      state_next = ST_INIT;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Column bookkeeping.
  always_ff @(posedge clk) begin
    if (rst || restart || restart_view) begin
      col_idx   <= '0;
      frame_idx <= '0;
      col_start <= '0;
      emit_ch   <= '0;
      res_count <= '0;
    end else begin
      if (frame_step) begin
        frame_idx <= frame_inc;
      end
      if (advance) begin
        col_start <= col_endb;
        col_idx   <= col_idx + COL_W'(1);
      end
      if (start_emit || chan_zero) begin
        emit_ch <= '0;
      end else if (next_ch) begin
        emit_ch <= emit_ch + CH_W'(1);
      end
      if (start_emit) begin
        res_count <= '0;
      end else if (emit_out || hold_load) begin
        res_count <= res_count + RES_W'(1);
      end
    end
  end

  // Boundary accumulator and the registered boundaries of the open column.
  always_ff @(posedge clk) begin
    if (refresh) begin
      col_endb     <= endb_new;
      col_close_m1 <= close_new;
      if (state == ST_INIT) begin
        accum <= acc_src;
      end
    end
    if (advance) begin
      accum <= accum + AccumW'(geom.fpp);
    end
  end

  // Min and max lanes: each lane watches its own channel.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      if (rst || restart || restart_view || (advance && (col_endb > frame_idx))) begin
        lane_min[i] <= SampleMax;
        lane_max[i] <= SampleMin;
      end else if (do_update && (it_ch == CH_W'(i))) begin
        if (it_sample < lane_min[i]) begin
          lane_min[i] <= it_sample;
        end
        if (it_sample > lane_max[i]) begin
          lane_max[i] <= it_sample;
        end
      end
    end
  end

  // Held last word of a column.
  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_pixel <= col_idx;
      hold_ch    <= emit_ch;
      hold_low   <= sel_min;
      hold_high  <= sel_max;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_out || release_hold) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_out) begin
      pixel      <= PixelW'(col_idx);
      channel    <= ChannelW'(emit_ch);
      low_value  <= sel_min;
      high_value <= sel_max;
      last       <= emit_last;
      view_done  <= final_col;
    end else if (release_hold) begin
      pixel      <= PixelW'(hold_pixel);
      channel    <= ChannelW'(hold_ch);
      low_value  <= hold_low;
      high_value <= hold_high;
      last       <= release_last;
      view_done  <= 1'b0;
    end
  end

  // The decision state is only reached right after a boundary refresh.
  a_decide_after_refresh: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE) |-> ($past(state) == ST_REFRESH || $past(state) == ST_DECIDE))
    else $error("decide state entered without a boundary refresh");

  // Results of one word never exceed the budget.
  a_result_budget: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_W'(MaxResults))
    else $error("result budget exceeded");

  // A widened column always ends at or after its start frame.
  a_close_after_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (col_close_m1 >= col_start))
    else $error("column closes before its start frame");

  // The final word of the view is marked both last and view done.
  a_view_end_marks: assert property (@(posedge clk) disable iff (rst || restart)
    (emit_out && emit_last) |=> (out_valid && last && view_done && col_idx == '0))
    else $error("view end not marked on the output");

  // A held word released as not last is always followed by another column.
  a_release_continues: assert property (@(posedge clk) disable iff (rst || restart)
    (release_hold && !release_last) |=> (state == ST_EMIT && emit_ch == '0))
    else $error("released word not followed by a column");

endmodule

@@ tb/waveform_minmax_decimator_core_test.sv @@
module waveform_minmax_decimator_core_test;
  import mmd_pkg::*;

  // Run limits, in clock cycles.
  localparam int unsigned LimitCycles = 1000000;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned QuietCycles = 32;
  localparam int unsigned LongHold    = 300;

  // Frames per column in Q16.16.
  localparam logic [WordW-1:0] OneFrame = 32'h0001_0000;
  localparam logic [WordW-1:0] MinStep  = 32'h0000_2000;
  localparam logic [WordW-1:0] AllOnes  = 32'hFFFF_FFFF;

  // One column word as the block reports it.
  typedef struct packed {
    logic [PixelW-1:0]         pixel;
    logic [ChannelW-1:0]       channel;
    logic signed [SampleW-1:0] low_value;
    logic signed [SampleW-1:0] high_value;
    logic                      last;
    logic                      view_done;
  } column_peak_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [SampleW-1:0] sample;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [PixelW-1:0]         pixel;
  logic [ChannelW-1:0]       channel;
  logic signed [SampleW-1:0] low_value;
  logic signed [SampleW-1:0] high_value;
  logic                      last;
  logic                      view_done;
  logic                      cfg_write;
  mmd_cfg_index_t            cfg_index;
  logic [WordW-1:0]          cfg_data;

  waveform_minmax_decimator_core dut (.*);

  // Column peaks still owed by the block, oldest first.
  column_peak_t peak_queue[$];
  column_peak_t want;
  int unsigned  failures = 0;
  int unsigned  predicted_words = 0;

  // Idling controls for the sender and the receiver.
  bit          idle_on = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ready_gap = 0;

  // Predictor copy of the registers and the view state.
  logic [WordW-1:0]          reg_fpp;
  logic [12:0]               reg_pixels;
  logic [3:0]                reg_channels;
  logic [WordW-1:0]          reg_span;
  logic [AccumW-1:0]         bound_accum;
  int unsigned               col_now;
  int unsigned               frame_now;
  int unsigned               chan_now;
  int unsigned               col_first;
  logic signed [SampleW-1:0] run_min[MaxChannels];
  logic signed [SampleW-1:0] run_max[MaxChannels];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #(2 * LimitCycles);
    $display("simulation failed");
    $finish;
  end

  // Counts out of range act as the nearest legal count.
  function automatic int unsigned active_pixels();
    if (reg_pixels == 0) return 1;
    if (reg_pixels > MaxPixels) return MaxPixels;
    return reg_pixels;
  endfunction

  function automatic int unsigned active_channels();
    if (reg_channels == 0) return 1;
    if (reg_channels > MaxChannels) return MaxChannels;
    return reg_channels;
  endfunction

  function automatic void clear_peaks();
    for (int i = 0; i < MaxChannels; i++) begin
      run_min[i] = SampleMax;
      run_max[i] = SampleMin;
    end
  endfunction

  function automatic void rewind_view();
    bound_accum = reg_fpp;
    col_now = 0;
    frame_now = 0;
    chan_now = 0;
    col_first = 0;
    clear_peaks();
  endfunction

  // Frame at which the current column ends; the last column always ends at the span.
  function automatic longint unsigned column_end();
    longint unsigned b;
    if (col_now + 1 >= active_pixels()) return reg_span;
    b = bound_accum >> FracW;
    return (b > reg_span) ? reg_span : b;
  endfunction

  function automatic void predict_config(input mmd_cfg_index_t idx,
                                         input logic [WordW-1:0] value);
    case (idx)
      CFG_FPP:      reg_fpp = value;
      CFG_PIXELS:   reg_pixels = value[12:0];
      CFG_CHANNELS: reg_channels = value[3:0];
      CFG_SPAN:     reg_span = value;
      default: ;
    endcase
    rewind_view();
  endfunction

  // Folds one sample into the running peaks and queues every column that closes.
  function automatic void predict_peaks(input logic signed [SampleW-1:0] s);
    int unsigned     nch;
    int unsigned     npx;
    int unsigned     ch;
    int unsigned     cap;
    int unsigned     cols;
    int unsigned     queued;
    longint unsigned f;
    longint unsigned endb;
    longint unsigned reach;
    bit              final_col;
    bit              restarted;
    column_peak_t    r;
    nch = active_channels();
    npx = active_pixels();
    ch = chan_now;
    if (ch >= nch) ch = 0;
    if (s < run_min[ch]) run_min[ch] = s;
    if (s > run_max[ch]) run_max[ch] = s;
    if (ch + 1 < nch) begin
      chan_now = ch + 1;
      return;
    end
    chan_now = 0;

    // A frame is complete: close columns up to the cap for this word.
    f = frame_now;
    cap = MaxResults / nch;
    cols = 0;
    queued = 0;
    restarted = 1'b0;
    while (cols < cap) begin
      endb = column_end();
      reach = endb;
      if (reach < longint'(col_first) + 1) reach = longint'(col_first) + 1;
      if (reach > f + 1) break;
      final_col = (col_now + 1 >= npx);
      for (int unsigned c = 0; c < nch; c++) begin
        r.pixel = col_now[PixelW-1:0];
        r.channel = c[ChannelW-1:0];
        r.low_value = run_min[c];
        r.high_value = run_max[c];
        r.last = 1'b0;
        r.view_done = final_col;
        peak_queue.push_back(r);
        queued++;
      end
      cols++;
      if (final_col) begin
        rewind_view();
        restarted = 1'b1;
        break;
      end
      col_first = endb[31:0];
      col_now++;
      bound_accum = bound_accum + reg_fpp;
      if (col_first > f) clear_peaks();
    end
    if (!restarted) frame_now = (f + 1 > AllOnes) ? AllOnes : 32'(f + 1);

    // Mark the final word caused by this sample.
    if (queued != 0) begin
      r = peak_queue[peak_queue.size() - 1];
      r.last = 1'b1;
      peak_queue[peak_queue.size() - 1] = r;
    end
    predicted_words += queued;
  endfunction

  // Compare each accepted word with the oldest expected column peak.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      ready_gap = idle_on ? $urandom_range(0, 3) : 0;
      if (peak_queue.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected word: pixel %0d channel %0d low %0d high %0d",
                   pixel, channel, low_value, high_value);
      end else begin
        want = peak_queue.pop_front();
        if (pixel !== want.pixel || channel !== want.channel ||
            low_value !== want.low_value || high_value !== want.high_value ||
            last !== want.last || view_done !== want.view_done) begin
          failures++;
          if (failures <= 10) begin
            $display("word mismatch: expected pixel %0d channel %0d low %0d high %0d last %0b done %0b",
                     want.pixel, want.channel, want.low_value, want.high_value,
                     want.last, want.view_done);
            $display("               got      pixel %0d channel %0d low %0d high %0d last %0b done %0b",
                     pixel, channel, low_value, high_value, last, view_done);
          end
        end
      end
    end
  end

  // Receiver: random gaps after each word, and one long hold on request.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (ready_gap != 0) begin
      out_ready <= 1'b0;
      ready_gap--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Offers one sample word and waits until it is taken; entered and left at a falling edge.
  task automatic send_sample(input logic signed [SampleW-1:0] value);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (!in_ready);
    predict_peaks(value);
    @(negedge clk);
  endtask

  // Drives one register write and leaves the write enable high for a following one.
  task automatic put_reg(input mmd_cfg_index_t idx, input logic [WordW-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    predict_config(idx, value);
  endtask

  task automatic program_view(input logic [WordW-1:0] fpp, input logic [WordW-1:0] pixels,
                              input logic [WordW-1:0] channels,
                              input logic [WordW-1:0] span);
    put_reg(CFG_FPP, fpp);
    put_reg(CFG_PIXELS, pixels);
    put_reg(CFG_CHANNELS, channels);
    put_reg(CFG_SPAN, span);
    cfg_write <= 1'b0;
  endtask

  // Waits until every expected word has arrived, then lets the block settle.
  task automatic await_quiet();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (peak_queue.size() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    if (peak_queue.size() != 0) begin
      failures += peak_queue.size();
      $display("%0d expected words never arrived", peak_queue.size());
      peak_queue.delete();
    end
    repeat (QuietCycles) @(negedge clk);
  endtask

  // Register values after reset: one frame per column, two channels.
  task automatic test_reset_defaults();
    logic signed [SampleW-1:0] words[6] = '{SampleMin, SampleMax, SampleMax, SampleMin,
                                           16'sh0000, -16'sd1};
    idle_on = 1'b0;
    foreach (words[i]) send_sample(words[i]);
    await_quiet();
  endtask

  // Zero and oversized counts, saturated boundaries, narrow and deferred columns.
  task automatic test_count_limits();
    logic signed [SampleW-1:0] single[4] = '{16'sd100, -16'sd200, SampleMin, SampleMax};
    logic signed [SampleW-1:0] octet[8] = '{SampleMin, SampleMax, 16'sh0000, -16'sd1,
                                           16'sh5555, -16'sh5556, 16'sd1, -16'sd2};
    logic signed [SampleW-1:0] wide[3] = '{16'sd7, -16'sd7, 16'sd300};
    logic signed [SampleW-1:0] stacked[6] = '{16'sd10, -16'sd10, 16'sd20, -16'sd20,
                                             16'sh4000, -16'sh4000};
    idle_on = 1'b1;

    // Zero pixels and zero channels act as one of each.
    program_view(OneFrame, 0, 0, 2);
    foreach (single[i]) send_sample(single[i]);
    await_quiet();

    // Too many channels and pixels; eight columns of an eighth frame close per frame.
    program_view(MinStep, 13'h1FFF, 4'hF, 1);
    foreach (octet[i]) send_sample(octet[i]);
    await_quiet();

    // Largest step: every boundary saturates at the span.
    program_view(AllOnes, 3, 1, 2);
    foreach (wide[i]) send_sample(wide[i]);
    await_quiet();

    // More columns close in one frame than one word may report.
    program_view(OneFrame, 40, 2, 1);
    foreach (stacked[i]) send_sample(stacked[i]);
    await_quiet();
  endtask

  // All 4096 columns over a single frame; covers every pixel index.
  task automatic test_widest_view();
    idle_on = 1'b1;
    program_view(MinStep, MaxPixels, 1, 1);
    repeat (66) send_sample(SampleW'($urandom));
    await_quiet();
  endtask

  // The receiver stops for a long stretch while samples keep coming.
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    program_view(OneFrame, 48, 2, AllOnes);
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    repeat (60) send_sample(SampleW'($urandom));
    await_quiet();
  endtask

  // Random views with random samples until enough words have been checked.
  task automatic test_random_views();
    logic [WordW-1:0] fpp;
    logic [WordW-1:0] pixels;
    logic [WordW-1:0] channels;
    logic [WordW-1:0] span;
    int unsigned      sent;
    int unsigned      words_start;
    int unsigned      phases;
    sent = 0;
    phases = 0;
    words_start = predicted_words;
    while (sent < 380 || (predicted_words - words_start < 60 && phases < 40)) begin
      case ($urandom_range(0, 9))
        0:       fpp = MinStep;
        1:       fpp = AllOnes;
        2, 3:    fpp = $urandom_range(MinStep, AllOnes);
        default: fpp = $urandom_range(MinStep, 4 * OneFrame);
      endcase
      pixels = $urandom_range(0, 32);
      channels = $urandom_range(0, 15);
      // Bits above a register's width are dropped by the block.
      if ($urandom_range(0, 3) == 0) pixels[31:13] = 19'($urandom);
      if ($urandom_range(0, 3) == 0) channels[31:4] = 28'($urandom);
      case ($urandom_range(0, 9))
        0:       span = $urandom;
        1:       span = AllOnes;
        default: span = $urandom_range(1, 48);
      endcase
      if (span == 0) span = 1;
      idle_on = ($urandom_range(0, 3) != 0);
      program_view(fpp, pixels, channels, span);
      repeat ($urandom_range(16, 48)) begin
        send_sample(SampleW'($urandom));
        sent++;
      end
      await_quiet();
      phases++;
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    cfg_write = 1'b0;
    cfg_index = CFG_FPP;
    cfg_data = '0;
    reg_fpp = OneFrame;
    reg_pixels = 13'd1024;
    reg_channels = 4'd2;
    reg_span = 32'd1024;
    rewind_view();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_count_limits();
    test_widest_view();
    test_output_backpressure();
    test_random_views();

    await_quiet();
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
